// ===== sv/vpa_pkg.sv =====
// shared types, codes and defaults of the variable partition allocator
package vpa_pkg;

  localparam int DEF_MAX_PARTITIONS = 16;
  localparam int DEF_SIZE_BITS      = 16;
  localparam int DEF_ID_BITS        = 8;

  // fixed field widths of the channels
  localparam int PID_W      = 8;
  localparam int REQ_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int GRANT_W    = 16;
  localparam int INDEX_W    = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] RESET_MEMORY_TOTAL = 16'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY   = 2'd1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;

  localparam logic OP_ALLOC = 1'b0;

  localparam logic [STATUS_W-1:0] STAT_ALLOC    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOSPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FRAG     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FREED    = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd5;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_INS_RD,
    ST_INS_WR,
    ST_SPLIT_HI,
    ST_SPLIT_LO,
    ST_RM_RD,
    ST_RM_WR,
    ST_RESP
  } st_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic [GRANT_W-1:0]  granted;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ===== sv/vpa_ram.sv =====
// generic single write port ram with registered read
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/vpa_outreg.sv =====
// output register between the sequencer and the result channel
module vpa_outreg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  vpa_pkg::res_t                 res,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [vpa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import vpa_pkg::*;

  logic valid_r;
  res_t data_r;

  assign res_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  // status, granted_size, partition_index from bit 0 up
  assign out_tdata = {1'b0, data_r.index, data_r.granted, data_r.status};

endmodule

// ===== sv/vpa_seq.sv =====
// sequencer and shared compare/add unit that scans and edits the partition table
module vpa_seq #(
  parameter int MAX_PARTITIONS = vpa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = vpa_pkg::DEF_SIZE_BITS,
  parameter int ID_BITS        = vpa_pkg::DEF_ID_BITS,
  localparam int IW = $clog2(MAX_PARTITIONS),
  localparam int EW = 1 + ID_BITS + SIZE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [vpa_pkg::PID_W-1:0]     in_pid,
  input  logic [vpa_pkg::REQ_W-1:0]     in_req,
  input  logic                          cfg_we,
  input  logic [vpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vpa_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [IW-1:0]                 ram_raddr,
  input  logic [EW-1:0]                 ram_rdata,
  output logic                          ram_we,
  output logic [IW-1:0]                 ram_waddr,
  output logic [EW-1:0]                 ram_wdata,
  output logic                          res_valid,
  input  logic                          res_ready,
  output vpa_pkg::res_t                 res
);
  import vpa_pkg::*;

  localparam int CW = $clog2(MAX_PARTITIONS + 1);

  st_t                 state_r, state_nxt;
  logic [SIZE_BITS-1:0] mem_total_r, mem_total_nxt;
  logic [1:0]          policy_r, policy_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SIZE_BITS-1:0] free_total_r, free_total_nxt;
  logic                op_r, op_nxt;
  logic [ID_BITS-1:0]  pid_r, pid_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [CW-1:0]       issue_r, issue_nxt;
  logic                rv_r, rv_nxt;
  logic [IW-1:0]       ridx_r, ridx_nxt;
  logic                found_r, found_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic                prev_free_r, prev_free_nxt;
  logic [SIZE_BITS-1:0] prev_size_r, prev_size_nxt;
  logic                pf_r, pf_nxt;
  logic [SIZE_BITS-1:0] pf_size_r, pf_size_nxt;
  logic                want_next_r, want_next_nxt;
  logic                nf_r, nf_nxt;
  logic [SIZE_BITS-1:0] nf_size_r, nf_size_nxt;
  logic [CW-1:0]       src_r, src_nxt;
  logic                gap2_r, gap2_nxt;
  res_t                res_r, res_nxt;

  logic                 r_free;
  logic [ID_BITS-1:0]   r_owner;
  logic [SIZE_BITS-1:0] r_size;
  logic [SIZE_BITS-1:0] req_in;
  logic [CW-1:0]        pos_w, pos_p1, pos_p2, gap;
  logic [SIZE_BITS-1:0] cfg_total;

  assign r_free    = ram_rdata[EW-1];
  assign r_owner   = ram_rdata[SIZE_BITS +: ID_BITS];
  assign r_size    = ram_rdata[SIZE_BITS-1:0];
  assign req_in    = SIZE_BITS'(in_req);
  assign pos_w     = CW'(pos_r);
  assign pos_p1    = pos_w + CW'(1);
  assign pos_p2    = pos_w + CW'(2);
  assign gap       = gap2_r ? CW'(2) : CW'(1);
  assign cfg_total = SIZE_BITS'(cfg_data);

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      mem_total_r  <= SIZE_BITS'(RESET_MEMORY_TOTAL);
      policy_r     <= POL_FIRST;
      count_r      <= CW'(1);
      free_total_r <= SIZE_BITS'(RESET_MEMORY_TOTAL);
      rv_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mem_total_r  <= mem_total_nxt;
      policy_r     <= policy_nxt;
      count_r      <= count_nxt;
      free_total_r <= free_total_nxt;
      rv_r         <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pid_r       <= pid_nxt;
    req_r       <= req_nxt;
    issue_r     <= issue_nxt;
    ridx_r      <= ridx_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    best_r      <= best_nxt;
    prev_free_r <= prev_free_nxt;
    prev_size_r <= prev_size_nxt;
    pf_r        <= pf_nxt;
    pf_size_r   <= pf_size_nxt;
    want_next_r <= want_next_nxt;
    nf_r        <= nf_nxt;
    nf_size_r   <= nf_size_nxt;
    src_r       <= src_nxt;
    gap2_r      <= gap2_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mem_total_nxt  = mem_total_r;
    policy_nxt     = policy_r;
    count_nxt      = count_r;
    free_total_nxt = free_total_r;
    op_nxt         = op_r;
    pid_nxt        = pid_r;
    req_nxt        = req_r;
    issue_nxt      = issue_r;
    rv_nxt         = 1'b0;
    ridx_nxt       = ridx_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    best_nxt       = best_r;
    prev_free_nxt  = prev_free_r;
    prev_size_nxt  = prev_size_r;
    pf_nxt         = pf_r;
    pf_size_nxt    = pf_size_r;
    want_next_nxt  = want_next_r;
    nf_nxt         = nf_r;
    nf_size_nxt    = nf_size_r;
    src_nxt        = src_r;
    gap2_nxt       = gap2_r;
    res_nxt        = res_r;
    ram_raddr      = '0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, ID_BITS'(0), mem_total_r};
        state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_op;
          pid_nxt       = ID_BITS'(in_pid);
          req_nxt       = req_in;
          issue_nxt     = '0;
          found_nxt     = 1'b0;
          prev_free_nxt = 1'b0;
          want_next_nxt = 1'b0;
          nf_nxt        = 1'b0;
          res_nxt       = '{index: '0, granted: '0, status: STAT_NOSPACE};
          if (in_op == OP_ALLOC && (req_in == '0 || free_total_r < req_in)) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // one read issued per cycle, its data compared in the cycle after
        if (issue_r < count_r) begin
          ram_raddr = IW'(issue_r);
          ridx_nxt  = IW'(issue_r);
          issue_nxt = issue_r + CW'(1);
          rv_nxt    = 1'b1;
        end
        if (rv_r) begin
          if (op_r == OP_ALLOC) begin
            unique case (policy_r)
              POL_WORST: begin
                if (r_free && (!found_r || r_size > best_r)) begin
                  found_nxt = 1'b1;
                  pos_nxt   = ridx_r;
                  best_nxt  = r_size;
                end
              end
              POL_BEST: begin
                if (r_free && r_size >= req_r && (!found_r || r_size < best_r)) begin
                  found_nxt = 1'b1;
                  pos_nxt   = ridx_r;
                  best_nxt  = r_size;
                end
              end
              default: begin
                if (r_free && r_size >= req_r && !found_r) begin
                  found_nxt = 1'b1;
                  pos_nxt   = ridx_r;
                  best_nxt  = r_size;
                end
              end
            endcase
          end else begin
            if (!found_r && !r_free && r_owner == pid_r) begin
              found_nxt     = 1'b1;
              pos_nxt       = ridx_r;
              best_nxt      = r_size;
              pf_nxt        = prev_free_r;
              pf_size_nxt   = prev_size_r;
              want_next_nxt = 1'b1;
            end else if (want_next_r) begin
              nf_nxt        = r_free;
              nf_size_nxt   = r_size;
              want_next_nxt = 1'b0;
            end
            prev_free_nxt = r_free;
            prev_size_nxt = r_size;
          end
        end
        if (issue_r >= count_r && !rv_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (op_r == OP_ALLOC) begin
          if (!found_r || best_r < req_r) begin
            res_nxt   = '{index: '0, granted: '0, status: STAT_FRAG};
            state_nxt = ST_RESP;
          end else if (best_r == req_r) begin
            ram_we         = 1'b1;
            ram_waddr      = pos_r;
            ram_wdata      = {1'b0, pid_r, req_r};
            free_total_nxt = free_total_r - req_r;
            res_nxt        = '{index: INDEX_W'(pos_r), granted: GRANT_W'(req_r),
                               status: STAT_ALLOC};
            state_nxt      = ST_RESP;
          end else if (count_r >= CW'(MAX_PARTITIONS)) begin
            res_nxt   = '{index: '0, granted: '0, status: STAT_FULL};
            state_nxt = ST_RESP;
          end else begin
            free_total_nxt = free_total_r - req_r;
            res_nxt        = '{index: INDEX_W'(pos_r), granted: GRANT_W'(req_r),
                               status: STAT_ALLOC};
            src_nxt        = count_r - CW'(1);
            if (count_r > pos_p1) begin
              state_nxt = ST_INS_RD;
            end else begin
              state_nxt = ST_SPLIT_HI;
            end
          end
        end else begin
          if (!found_r) begin
            res_nxt   = '{index: '0, granted: '0, status: STAT_NOTFOUND};
            state_nxt = ST_RESP;
          end else begin
            free_total_nxt = free_total_r + best_r;
            res_nxt        = '{index: INDEX_W'(pos_r), granted: GRANT_W'(best_r),
                               status: STAT_FREED};
            ram_we         = 1'b1;
            gap2_nxt       = pf_r && nf_r;
            priority if (pf_r && nf_r) begin
              ram_waddr = IW'(pos_w - CW'(1));
              ram_wdata = {1'b1, pid_r, pf_size_r + best_r + nf_size_r};
              src_nxt   = pos_p2;
            end else if (pf_r) begin
              ram_waddr = IW'(pos_w - CW'(1));
              ram_wdata = {1'b1, pid_r, pf_size_r + best_r};
              src_nxt   = pos_p1;
            end else if (nf_r) begin
              ram_waddr = pos_r;
              ram_wdata = {1'b1, pid_r, best_r + nf_size_r};
              src_nxt   = pos_p2;
            end else begin
              ram_waddr = pos_r;
              ram_wdata = {1'b1, pid_r, best_r};
            end
            if (!pf_r && !nf_r) begin
              state_nxt = ST_RESP;
            end else if ((pf_r && !nf_r ? pos_p1 : pos_p2) < count_r) begin
              state_nxt = ST_RM_RD;
            end else begin
              count_nxt = count_r - ((pf_r && nf_r) ? CW'(2) : CW'(1));
              state_nxt = ST_RESP;
            end
          end
        end
      end

      ST_INS_RD: begin
        ram_raddr = IW'(src_r);
        state_nxt = ST_INS_WR;
      end

      ST_INS_WR: begin
        // move one entry up to open the slot behind the split hole
        ram_we    = 1'b1;
        ram_waddr = IW'(src_r + CW'(1));
        ram_wdata = ram_rdata;
        if (src_r == pos_p1) begin
          state_nxt = ST_SPLIT_HI;
        end else begin
          src_nxt   = src_r - CW'(1);
          state_nxt = ST_INS_RD;
        end
      end

      ST_SPLIT_HI: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(pos_p1);
        ram_wdata = {1'b1, pid_r, best_r - req_r};
        state_nxt = ST_SPLIT_LO;
      end

      ST_SPLIT_LO: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = {1'b0, pid_r, req_r};
        count_nxt = count_r + CW'(1);
        state_nxt = ST_RESP;
      end

      ST_RM_RD: begin
        ram_raddr = IW'(src_r);
        state_nxt = ST_RM_WR;
      end

      ST_RM_WR: begin
        // close the gap left by merged entries
        ram_we    = 1'b1;
        ram_waddr = IW'(src_r - gap);
        ram_wdata = ram_rdata;
        src_nxt   = src_r + CW'(1);
        if (src_r + CW'(1) < count_r) begin
          state_nxt = ST_RM_RD;
        end else begin
          count_nxt = count_r - gap;
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes are for the user to send only while idle; the block does not enforce it, and they simply win
    if (cfg_we) begin
      if (cfg_index == REG_MEMORY_TOTAL) begin
        mem_total_nxt  = cfg_total;
        free_total_nxt = cfg_total;
        count_nxt      = CW'(1);
        ram_we         = 1'b1;
        ram_waddr      = '0;
        ram_wdata      = {1'b1, ID_BITS'(0), cfg_total};
      end else if (cfg_index == REG_FIT_POLICY) begin
        policy_nxt = cfg_data[1:0];
      end
    end
  end

endmodule

// ===== sv/variable_partition_allocator_unit.sv =====
// top level of the variable partition allocator
//
// Keeps an ordered table of partitions in a small ram and serves one word
// at a time on the input channel: allocate (in_tuser low) or free
// (in_tuser high) for a process id. Each word gives exactly one result word.
// A word is taken when in_tvalid and in_tready are high; in_tready is high
// only while the sequencer is idle.
// An allocation short of space answers without a scan. Otherwise the table
// is scanned through the ram read port, one entry per cycle, then a split
// moves each entry behind the hole up by one and writes both halves, and a
// merging free moves each entry behind the merged ones down.
// The result sits in an output register, so the next word is accepted while
// it waits; if out_tready stays low the sequencer holds its next result and
// stops taking input. After reset an init state writes the first table entry.
// Writing memory_total rebuilds the table as one free partition.
module variable_partition_allocator_unit #(
  parameter int MAX_PARTITIONS = vpa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = vpa_pkg::DEF_SIZE_BITS,
  parameter int ID_BITS        = vpa_pkg::DEF_ID_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // process_id, request_size from bit 0 up
  input  logic [vpa_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status, granted_size, partition_index from bit 0 up
  output logic [vpa_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vpa_pkg::*;

  localparam int IW = $clog2(MAX_PARTITIONS);
  localparam int EW = 1 + ID_BITS + SIZE_BITS;

  logic [IW-1:0] ram_raddr, ram_waddr;
  logic [EW-1:0] ram_rdata, ram_wdata;
  logic          ram_we;
  logic          res_valid, res_ready;
  res_t          res;

  vpa_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_PARTITIONS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  vpa_seq #(
    .MAX_PARTITIONS(MAX_PARTITIONS),
    .SIZE_BITS     (SIZE_BITS),
    .ID_BITS       (ID_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_pid   (in_tdata[PID_W-1:0]),
    .in_req   (in_tdata[PID_W +: REQ_W]),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  vpa_outreg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
